### design/length_prefix_deframer_defines.svh
// Assertion macros shared by the length-prefix deframer modules.
`ifndef LENGTH_PREFIX_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIX_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lpd_pkg.sv
// Shared types and constants of the length-prefix deframer.
package lpd_pkg;

  localparam logic [1:0]  KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0]  KIND_EMPTY    = 2'd1;
  localparam logic [1:0]  KIND_OVERSIZE = 2'd2;

  localparam logic [1:0]  HDR_LAST_IDX    = 2'd3;
  localparam logic [31:0] MAX_FRAME_RESET = 32'd1048576;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        last;
    logic [31:0] declared_length;
  } lpd_result_t;

endpackage

### design/length_prefix_deframer.sv
// Top level of the length-prefix deframer.
//
// The block takes a raw byte stream, one byte per item on the input channel
// (in_valid_i, in_byte_i, in_stall_o), and splits it into frames that each
// start with a 4-byte big-endian length header. Payload bytes leave on the
// output channel (out_valid_o, out_stall_i) as they arrive, with last_o set on
// the final byte of a frame. A zero-length header gives one empty-frame item,
// and a header longer than the configured maximum gives one oversize item;
// the byte after an oversize header starts a new header. The first three
// header bytes give no output item.
// The maximum is written through cfg_valid_i / cfg_max_frame_bytes_i; the port
// is always ready, and writes are meant to happen while the block is idle.
// Throughput is one byte per cycle while the receiver does not stall: an input
// register feeds the header and countdown logic, whose result is caught in an
// output register, so an item passes both registers before it is on the output.
// When the receiver stalls, the output register holds its item and the input
// register holds one more byte, after which in_stall_o rises.
// Reset clears all framing state, empties both registers and sets the
// maximum frame length to 1048576 bytes.
`include "length_prefix_deframer_defines.svh"

module length_prefix_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  in_byte_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [31:0] declared_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_max_frame_bytes_i
);

  logic                 advance;
  logic                 fire;
  logic [7:0]           core_byte;
  logic                 res_valid;
  lpd_pkg::lpd_result_t core_res;
  lpd_pkg::lpd_result_t out_res;

  assign cfg_ready_o = 1'b1;

  lpd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_stall_o (in_stall_o),
    .advance_i  (advance),
    .fire_o     (fire),
    .byte_o     (core_byte)
  );

  lpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (core_byte),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_max_i   (cfg_max_frame_bytes_i),
    .res_valid_o (res_valid),
    .res_o       (core_res)
  );

  // Only bytes that actually move through the core may load a result.
  lpd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire & res_valid),
    .res_i       (core_res),
    .out_stall_i (out_stall_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign kind_o            = out_res.kind;
  assign out_byte_o        = out_res.out_byte;
  assign last_o            = out_res.last;
  assign declared_length_o = out_res.declared_length;

  `LPD_ASSERT_IMP(a_byte_only_payload, clk_i, rst_ni, out_valid_o && (kind_o != lpd_pkg::KIND_PAYLOAD), out_byte_o == 8'd0, "nonzero byte on a non-payload item")
  `LPD_ASSERT_IMP(a_empty_shape, clk_i, rst_ni, out_valid_o && (kind_o == lpd_pkg::KIND_EMPTY), last_o && (declared_length_o == 32'd0), "malformed empty-frame item")
  `LPD_ASSERT_IMP(a_oversize_shape, clk_i, rst_ni, out_valid_o && (kind_o == lpd_pkg::KIND_OVERSIZE), !last_o && (declared_length_o != 32'd0), "malformed oversize item")

endmodule

### design/lpd_in_stage.sv
// Input register of the deframer: holds one accepted byte until the core takes it.
module lpd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_stall_o,
  input  logic       advance_i,
  output logic       fire_o,
  output logic [7:0] byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       accept;

  // The held byte moves on whenever the result side can take a new result.
  assign fire_o     = vld_q & advance_i;
  assign in_stall_o = vld_q & ~advance_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign byte_o     = byte_q;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (fire_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

### design/lpd_core.sv
// Header collection, length check and payload countdown of the deframer.
`include "length_prefix_deframer_defines.svh"

module lpd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_max_i,
  output logic                res_valid_o,
  output lpd_pkg::lpd_result_t res_o
);

  logic [31:0] max_q;
  logic [23:0] collect_q, collect_d;
  logic [1:0]  hdr_idx_q, hdr_idx_d;
  logic        in_payload_q, in_payload_d;
  logic [31:0] bytes_left_q, bytes_left_d;
  logic [31:0] frame_len_q, frame_len_d;
  logic [31:0] length;

  assign length = {collect_q, byte_i};

  always_comb begin
    collect_d    = collect_q;
    hdr_idx_d    = hdr_idx_q;
    in_payload_d = in_payload_q;
    bytes_left_d = bytes_left_q;
    frame_len_d  = frame_len_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (in_payload_q && (bytes_left_q != 32'd0)) begin
      // Payload byte: pass it through and count down.
      res_valid_o           = 1'b1;
      res_o.kind            = lpd_pkg::KIND_PAYLOAD;
      res_o.out_byte        = byte_i;
      res_o.last            = (bytes_left_q == 32'd1);
      res_o.declared_length = frame_len_q;
      bytes_left_d          = bytes_left_q - 32'd1;
      in_payload_d          = (bytes_left_q != 32'd1);
    end else if (hdr_idx_q != lpd_pkg::HDR_LAST_IDX) begin
      in_payload_d = 1'b0;
      collect_d    = {collect_q[15:0], byte_i};
      hdr_idx_d    = hdr_idx_q + 2'd1;
    end else begin
      // Fourth header byte completes the length.
      in_payload_d = 1'b0;
      collect_d    = '0;
      hdr_idx_d    = '0;
      frame_len_d  = length;
      if (length > max_q) begin
        res_valid_o           = 1'b1;
        res_o.kind            = lpd_pkg::KIND_OVERSIZE;
        res_o.declared_length = length;
      end else if (length == 32'd0) begin
        res_valid_o = 1'b1;
        res_o.kind  = lpd_pkg::KIND_EMPTY;
        res_o.last  = 1'b1;
      end else begin
        in_payload_d = 1'b1;
        bytes_left_d = length;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q        <= lpd_pkg::MAX_FRAME_RESET;
      collect_q    <= '0;
      hdr_idx_q    <= '0;
      in_payload_q <= 1'b0;
      bytes_left_q <= '0;
      frame_len_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_max_i;
      end
      if (fire_i) begin
        collect_q    <= collect_d;
        hdr_idx_q    <= hdr_idx_d;
        in_payload_q <= in_payload_d;
        bytes_left_q <= bytes_left_d;
        frame_len_q  <= frame_len_d;
      end
    end
  end

  `LPD_ASSERT_IMP(a_payload_has_bytes, clk_i, rst_ni, in_payload_q, bytes_left_q != 32'd0, "payload mode with no bytes left")
  `LPD_ASSERT_IMP(a_payload_no_header, clk_i, rst_ni, in_payload_q, hdr_idx_q == 2'd0, "header bytes pending in payload mode")
  `LPD_ASSERT_IMP(a_header_clean_start, clk_i, rst_ni, hdr_idx_q == 2'd0, collect_q == 24'd0, "stale header bytes at header start")

endmodule

### design/lpd_out_stage.sv
// Result register of the deframer: holds one result until the receiver takes it.
module lpd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  lpd_pkg::lpd_result_t res_i,
  input  logic                out_stall_i,
  output logic                advance_o,
  output logic                out_valid_o,
  output lpd_pkg::lpd_result_t res_o
);

  logic                 vld_q;
  lpd_pkg::lpd_result_t res_q;

  // The register can be refilled when empty or when its result leaves now.
  assign advance_o   = ~vld_q | ~out_stall_i;
  assign out_valid_o = vld_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (advance_o) begin
      vld_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule

### dv/testbench.sv
// Self-checking testbench for the length-prefix deframer.
//
// The testbench feeds a byte stream into the deframer and predicts every output
// item in step with the stream. A byte is predicted at the clock edge where the
// deframer accepts it, and each prediction is queued. A separate process takes
// each output item the deframer hands over and compares it, field by field,
// with the oldest queued prediction.
//
// The tests run in turn:
//   - directed framing at the reset maximum: an empty frame, a one-byte frame,
//     a header one past the maximum, a two-byte frame and an all-ones header;
//   - maximum length settings: zero, a small limit with its exact boundary,
//     and a limit change in the middle of a frame;
//   - three random phases with changing idle rates on both channels;
//   - backpressure: the receiver holds off long enough that the deframer stalls
//     its input, and then the sender waits for the output to drain;
//   - an all-ones length under an all-ones maximum. That frame never ends, so
//     this test runs last.
module testbench;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 200;

  logic        clk_i                 = 1'b0;
  logic        rst_ni                = 1'b0;
  logic        in_valid_i            = 1'b0;
  logic [7:0]  in_byte_i             = 8'd0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i           = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic        last_o;
  logic [31:0] declared_length_o;
  logic        cfg_valid_i           = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_max_frame_bytes_i = 32'd0;

  length_prefix_deframer dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_byte_i             (in_byte_i),
    .in_stall_o            (in_stall_o),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .kind_o                (kind_o),
    .out_byte_o            (out_byte_o),
    .last_o                (last_o),
    .declared_length_o     (declared_length_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_max_frame_bytes_i (cfg_max_frame_bytes_i)
  );

  always #4 clk_i = ~clk_i;

  // Framing state of the prediction. It mirrors what the deframer must hold:
  // the header bytes seen so far, how many there are, whether payload is
  // flowing, how much payload is left and the length of the current frame.
  logic [23:0] hdr_bytes    = 24'd0;
  logic [1:0]  hdr_count    = 2'd0;
  logic        payload_mode = 1'b0;
  logic [31:0] remaining    = 32'd0;
  logic [31:0] cur_length   = 32'd0;
  logic [31:0] max_len      = lpd_pkg::MAX_FRAME_RESET;

  // Output items that the deframer still owes, oldest first.
  lpd_pkg::lpd_result_t deframed_items[$];

  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned cycle_count    = 0;

  // Idle rates in percent. The sender drops valid after an item with this
  // chance; the receiver raises stall on any cycle with its own chance.
  int unsigned send_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;

  // A long receiver hold-off is requested by bumping hold_requests. The
  // receiver process counts the hold down by itself.
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;

  // Append one predicted item behind the ones already owed.
  function automatic void owe_item(input lpd_pkg::lpd_result_t item);
    deframed_items.insert(deframed_items.size(), item);
  endfunction

  // Predict the effect of one accepted byte and queue any output item.
  function automatic void deframe_byte(input logic [7:0] value);
    lpd_pkg::lpd_result_t item;
    logic [31:0] length;
    item = '0;
    if (payload_mode && remaining != 32'd0) begin
      item.kind            = lpd_pkg::KIND_PAYLOAD;
      item.out_byte        = value;
      item.last            = (remaining == 32'd1);
      item.declared_length = cur_length;
      owe_item(item);
      remaining = remaining - 32'd1;
      if (remaining == 32'd0) begin
        payload_mode = 1'b0;
      end
      return;
    end
    payload_mode = 1'b0;
    if (hdr_count < lpd_pkg::HDR_LAST_IDX) begin
      hdr_bytes = {hdr_bytes[15:0], value};
      hdr_count = hdr_count + 2'd1;
      return;
    end
    // The fourth header byte completes the length.
    length     = {hdr_bytes, value};
    hdr_bytes  = 24'd0;
    hdr_count  = 2'd0;
    cur_length = length;
    if (length > max_len) begin
      // The header is dropped; the next byte opens a new header.
      item.kind            = lpd_pkg::KIND_OVERSIZE;
      item.declared_length = length;
      owe_item(item);
    end else if (length == 32'd0) begin
      item.kind = lpd_pkg::KIND_EMPTY;
      item.last = 1'b1;
      owe_item(item);
    end else begin
      payload_mode = 1'b1;
      remaining    = length;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Receiver: checks each handed-over item and drives stall for the next edge.
  always @(posedge clk_i) begin : receive_items
    lpd_pkg::lpd_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (deframed_items.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual kind %0d byte 0x%0h last %0b length 0x%0h",
                   $time, kind_o, out_byte_o, last_o, declared_length_o);
          mismatch_count++;
        end else begin
          want = deframed_items.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_o));
          check_field("out_byte", 32'(want.out_byte), 32'(out_byte_o));
          check_field("last", 32'(want.last), 32'(last_o));
          check_field("declared_length", want.declared_length, declared_length_o);
        end
      end
      if (hold_requests != holds_served) begin
        holds_served <= hold_requests;
        hold_left    <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one byte, wait until it is taken, then maybe leave a gap. Valid stays
  // high when no gap follows, so back-to-back items are offered without a gap.
  task automatic send_byte(input logic [7:0] value);
    in_valid_i <= 1'b1;
    in_byte_i  <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    deframe_byte(value);
    bytes_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_header(input logic [31:0] length);
    send_byte(length[31:24]);
    send_byte(length[23:16]);
    send_byte(length[15:8]);
    send_byte(length[7:0]);
  endtask

  // A whole frame: the header, plus random payload when the length is accepted.
  task automatic send_frame(input logic [31:0] length);
    send_header(length);
    if (length != 32'd0 && length <= max_len) begin
      repeat (length) send_byte(8'($urandom_range(255)));
    end
  endtask

  // Feed random bytes until the deframer waits for the first header byte.
  task automatic realign_stream();
    while (payload_mode || hdr_count != 2'd0) send_byte(8'($urandom_range(255)));
  endtask

  // Stop offering, wait for every owed item, then let the pipeline settle:
  // header bytes give no item, so the deframer may still be busy with one.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (deframed_items.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Only called right after wait_for_drain, so the deframer is idle.
  task automatic write_max_frame(input logic [31:0] value);
    cfg_valid_i           <= 1'b1;
    cfg_max_frame_bytes_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    max_len = value;
  endtask

  function automatic logic [31:0] random_length();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return 32'd0;
    if (pick < 18) return max_len + 32'd1;
    if (pick < 22) return 32'hFFFF_FFFF;
    if (pick < 26) return max_len;
    return $urandom_range(1, (max_len < 12) ? max_len : 12);
  endfunction

  task automatic test_directed_framing();
    send_frame(32'd0);
    send_header(32'd1);
    send_byte(8'hFF);
    // One past the reset maximum is dropped and the next byte starts a header.
    send_header(lpd_pkg::MAX_FRAME_RESET + 32'd1);
    send_header(32'd2);
    send_byte(8'h00);
    send_byte(8'h80);
    send_header(32'hFFFF_FFFF);
  endtask

  task automatic test_max_length_setting();
    wait_for_drain();
    // With a zero maximum only empty frames pass.
    write_max_frame(32'd0);
    send_frame(32'd0);
    send_frame(32'd1);
    send_frame(32'hFFFF_FFFF);
    wait_for_drain();
    // A length equal to the maximum passes, one more is oversize.
    write_max_frame(32'd3);
    send_frame(32'd3);
    send_frame(32'd4);
    // A new maximum written mid-frame leaves the open frame alone.
    send_header(32'd3);
    send_byte(8'($urandom_range(255)));
    wait_for_drain();
    write_max_frame(32'd0);
    send_byte(8'($urandom_range(255)));
    send_byte(8'($urandom_range(255)));
    send_frame(32'd2);
  endtask

  // Mostly well-formed frames, with noise bytes and cut-off frames mixed in.
  task automatic test_random_framing(input int unsigned idle_in, input int unsigned idle_out,
                                     input logic [31:0] limit, input int unsigned count);
    int unsigned first;
    int unsigned pick;
    logic [31:0] length;
    wait_for_drain();
    write_max_frame(limit);
    send_idle_pct = idle_in;
    rcv_stall_pct = idle_out;
    first = bytes_sent;
    while (bytes_sent - first < count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
      end else if (pick < 14) begin
        realign_stream();
        length = $urandom_range(2, (max_len < 12) ? max_len : 12);
        send_header(length);
        repeat ($urandom_range(1, length - 1)) send_byte(8'($urandom_range(255)));
      end else begin
        realign_stream();
        send_frame(random_length());
      end
    end
  endtask

  task automatic test_backpressure();
    wait_for_drain();
    write_max_frame(32'd64);
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    // The receiver holds off while the sender keeps offering, so the deframer
    // fills up and stalls its input.
    hold_requests <= hold_requests + 1;
    repeat (6) send_frame($urandom_range(8, 12));
    // Pause until everything has come out, then carry on.
    wait_for_drain();
    repeat (4) send_frame(random_length());
  endtask

  task automatic test_largest_length();
    wait_for_drain();
    write_max_frame(32'hFFFF_FFFF);
    realign_stream();
    send_header(32'hFFFF_FFFF);
    repeat (12) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 24;
    rcv_stall_pct = 60;
    test_directed_framing();
    test_max_length_setting();
    test_random_framing(24, 60, $urandom_range(8, 40), 230);
    test_random_framing(60, 24, 32'd100, 230);
    test_random_framing(0, 0, 32'd12, 230);
    test_backpressure();
    test_largest_length();
    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
